### design/image_header_dimension_parser_defines.svh
// ----------------------------------------------------------------------------
// Image header dimension parser: assertion macros
// Shared assertion forms for the design files. Each use names clk and rst_n
// of the module that expands it.
// ----------------------------------------------------------------------------
`ifndef IMAGE_HEADER_DIMENSION_PARSER_DEFINES_SVH
`define IMAGE_HEADER_DIMENSION_PARSER_DEFINES_SVH

// Check a property on every clock edge outside reset
`define IDHP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on every clock edge, reset included
`define IDHP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### design/idhp_pkg.sv
// ----------------------------------------------------------------------------
// Image header dimension parser package
// Request and result types, parser state, phase and verdict codes, and the
// PNG signature tables.
// ----------------------------------------------------------------------------
package idhp_pkg;

  // Input request: one file byte with its framing
  typedef struct packed {
    logic [7:0]  data_byte;
    logic        start_of_file;
    logic        end_of_file;
    logic [31:0] file_length;
  } idhp_in_t;

  // Result: verdict and dimensions
  typedef struct packed {
    logic [1:0]  image_kind;
    logic [31:0] image_width;
    logic [31:0] image_height;
  } idhp_out_t;

  // Parse phases
  localparam logic [3:0] PH_IDLE   = 4'd0;
  localparam logic [3:0] PH_DONE   = 4'd1;
  localparam logic [3:0] PH_FIRST  = 4'd2;
  localparam logic [3:0] PH_PNG    = 4'd3;
  localparam logic [3:0] PH_JSOI   = 4'd4;
  localparam logic [3:0] PH_JTOP   = 4'd5;
  localparam logic [3:0] PH_JFILL  = 4'd6;
  localparam logic [3:0] PH_JLENHI = 4'd7;
  localparam logic [3:0] PH_JLENLO = 4'd8;
  localparam logic [3:0] PH_JSKIP  = 4'd9;
  localparam logic [3:0] PH_JSOF   = 4'd10;

  // Verdicts; PNG and JPEG codes match the image_kind codes
  localparam logic [1:0] V_UNDECIDED = 2'd0;
  localparam logic [1:0] V_PNG       = 2'd1;
  localparam logic [1:0] V_JPEG      = 2'd2;
  localparam logic [1:0] V_REJECT    = 2'd3;

  localparam logic [1:0] KIND_REJECT = 2'd0;

  // Marker and length constants
  localparam logic [7:0]  PNG_LEAD     = 8'h89;
  localparam logic [7:0]  JPG_FILL     = 8'hFF;
  localparam logic [7:0]  JPG_SOI      = 8'hD8;
  localparam logic [7:0]  JPG_EOI      = 8'hD9;
  localparam logic [7:0]  JPG_SOS      = 8'hDA;
  localparam logic [7:0]  JPG_RST_LO   = 8'hD0;
  localparam logic [7:0]  JPG_RST_HI   = 8'hD7;
  localparam logic [7:0]  JPG_SOF_LO   = 8'hC0;
  localparam logic [7:0]  JPG_SOF_HI   = 8'hCF;
  localparam logic [7:0]  JPG_DHT      = 8'hC4;
  localparam logic [7:0]  JPG_JPG      = 8'hC8;
  localparam logic [7:0]  JPG_DAC      = 8'hCC;
  localparam logic [31:0] PNG_MIN_LEN  = 32'd24;
  localparam logic [31:0] JPG_MIN_LEN  = 32'd4;
  localparam logic [15:0] SEG_MIN_LEN  = 16'd2;
  localparam logic [15:0] SOF_MIN_LEN  = 16'd7;

  // Parser state
  typedef struct packed {
    logic [3:0]  phase;
    logic [31:0] rem;        // bytes of the file still to come
    logic [4:0]  pos;        // byte position, saturating, for the PNG header
    logic [7:0]  len_hi;     // high byte of a JPEG segment length
    logic [15:0] seg_rem;    // skip count, or byte index inside start-of-frame
    logic        frame_seg;  // current segment is a start-of-frame
    logic [31:0] width;
    logic [31:0] height;
    logic [1:0]  verdict;
  } idhp_state_t;

  // PNG signature byte at a position
  function automatic logic [7:0] png_sig_byte(input logic [2:0] idx);
    logic [7:0] val;
    case (idx)
      3'd0: val = 8'h89;
      3'd1: val = 8'h50;
      3'd2: val = 8'h4E;
      3'd3: val = 8'h47;
      3'd4: val = 8'h0D;
      3'd5: val = 8'h0A;
      3'd6: val = 8'h1A;
      3'd7: val = 8'h0A;
      default: val = 8'h00;
    endcase
    return val;
  endfunction

  // IHDR chunk tag byte at a position
  function automatic logic [7:0] ihdr_byte(input logic [1:0] idx);
    logic [7:0] val;
    case (idx)
      2'd0: val = 8'h49;
      2'd1: val = 8'h48;
      2'd2: val = 8'h44;
      2'd3: val = 8'h52;
      default: val = 8'h00;
    endcase
    return val;
  endfunction

  // Start-of-frame markers, without DHT, JPG and DAC
  function automatic logic is_frame_marker(input logic [7:0] m);
    return (m >= JPG_SOF_LO) && (m <= JPG_SOF_HI) &&
           (m != JPG_DHT) && (m != JPG_JPG) && (m != JPG_DAC);
  endfunction

endpackage

### design/idhp_step.sv
// ----------------------------------------------------------------------------
// Image header dimension parser: byte step
// Next parser state for one accepted byte, and the verdict that an end of
// file byte gives.
// ----------------------------------------------------------------------------
module idhp_step #(
  parameter logic [31:0] MAX_FILE_BYTES = 32'd16777216
) (
  input  idhp_pkg::idhp_state_t st_i,
  input  idhp_pkg::idhp_in_t    req_i,
  output idhp_pkg::idhp_state_t st_o,
  output logic                  res_valid_o,
  output idhp_pkg::idhp_out_t   res_o
);
  import idhp_pkg::*;

  idhp_state_t s;
  logic [3:0]  ph;
  logic [31:0] r0;
  logic [4:0]  p;
  logic [7:0]  b;
  logic [15:0] seg;
  logic [31:0] h_new;
  logic [32:0] seg_room;

  assign b        = req_i.data_byte;
  assign seg      = {st_i.len_hi, req_i.data_byte};
  assign seg_room = {1'b0, st_i.rem} + 33'd1;

  always_comb begin
    s     = st_i;
    h_new = '0;
    res_valid_o = 1'b0;
    res_o = '0;

    // Restart on the first byte of a file
    if (req_i.start_of_file) begin
      s = '0;
      s.phase   = PH_FIRST;
      s.rem     = req_i.file_length;
      s.verdict = V_UNDECIDED;
    end

    ph = s.phase;
    r0 = s.rem;
    p  = s.pos;

    if (ph != PH_IDLE) begin
      if (r0 == '0) begin
        // Byte beyond the declared length
        s.verdict = V_REJECT;
        s.phase   = PH_DONE;
      end else begin
        s.rem = r0 - 32'd1;
        if (p != '1) begin
          s.pos = p + 5'd1;
        end
        case (ph)
          PH_FIRST: begin
            if (r0 > MAX_FILE_BYTES) begin
              s.verdict = V_REJECT;
              s.phase   = PH_DONE;
            end else if (b == PNG_LEAD && r0 >= PNG_MIN_LEN) begin
              s.phase = PH_PNG;
            end else if (b == JPG_FILL && r0 >= JPG_MIN_LEN) begin
              s.phase = PH_JSOI;
            end else begin
              s.verdict = V_REJECT;
              s.phase   = PH_DONE;
            end
          end
          PH_PNG: begin
            if (p < 5'd8) begin
              if (b != png_sig_byte(p[2:0])) begin
                s.verdict = V_REJECT;
                s.phase   = PH_DONE;
              end
            end else if (p >= 5'd12 && p < 5'd16) begin
              if (b != ihdr_byte(p[1:0])) begin
                s.verdict = V_REJECT;
                s.phase   = PH_DONE;
              end
            end else if (p >= 5'd16 && p < 5'd20) begin
              s.width = {st_i.width[23:0], b};
            end else if (p >= 5'd20 && p < 5'd24) begin
              h_new    = {s.height[23:0], b};
              s.height = h_new;
              if (p == 5'd23) begin
                if (s.width != '0 && h_new != '0) begin
                  s.verdict = V_PNG;
                end else begin
                  s.verdict = V_REJECT;
                end
                s.phase = PH_DONE;
              end
            end
          end
          PH_JSOI: begin
            if (b == JPG_SOI) begin
              s.phase = PH_JTOP;
            end else begin
              s.verdict = V_REJECT;
              s.phase   = PH_DONE;
            end
          end
          PH_JTOP, PH_JFILL: begin
            if (ph == PH_JTOP && r0 <= 32'd3) begin
              s.verdict = V_REJECT;
              s.phase   = PH_DONE;
            end else if (b == JPG_FILL) begin
              s.phase = PH_JFILL;
            end else if (b == JPG_SOI || (b >= JPG_RST_LO && b <= JPG_RST_HI)) begin
              // Standalone marker
              s.phase = PH_JTOP;
            end else if (b == JPG_EOI || b == JPG_SOS || r0 <= 32'd2) begin
              s.verdict = V_REJECT;
              s.phase   = PH_DONE;
            end else begin
              s.frame_seg = is_frame_marker(b);
              s.phase     = PH_JLENHI;
            end
          end
          PH_JLENHI: begin
            s.len_hi = b;
            s.phase  = PH_JLENLO;
          end
          PH_JLENLO: begin
            if (seg < SEG_MIN_LEN || {17'd0, seg} > seg_room) begin
              s.verdict = V_REJECT;
              s.phase   = PH_DONE;
            end else if (s.frame_seg) begin
              if (seg < SOF_MIN_LEN) begin
                s.verdict = V_REJECT;
                s.phase   = PH_DONE;
              end else begin
                s.seg_rem = '0;
                s.width   = '0;
                s.height  = '0;
                s.phase   = PH_JSOF;
              end
            end else begin
              s.seg_rem = seg - SEG_MIN_LEN;
              s.phase   = (seg == SEG_MIN_LEN) ? PH_JTOP : PH_JSKIP;
            end
          end
          PH_JSKIP: begin
            s.seg_rem = s.seg_rem - 16'd1;
            if (s.seg_rem == 16'd0) begin
              s.phase = PH_JTOP;
            end
          end
          PH_JSOF: begin
            // Precision byte, then height and width, high byte first
            if (s.seg_rem == 16'd1 || s.seg_rem == 16'd2) begin
              s.height = {16'd0, s.height[7:0], b};
            end else if (s.seg_rem == 16'd3 || s.seg_rem == 16'd4) begin
              s.width = {16'd0, s.width[7:0], b};
              if (s.seg_rem == 16'd4) begin
                if (s.width[15:0] != '0 && s.height != '0) begin
                  s.verdict = V_JPEG;
                end else begin
                  s.verdict = V_REJECT;
                end
                s.phase = PH_DONE;
              end
            end
            s.seg_rem = st_i.seg_rem + 16'd1;
          end
          default: begin
            // Decided: later bytes only count towards the length
          end
        endcase
      end
    end

    // Give the verdict and close the file
    if (req_i.end_of_file) begin
      res_valid_o = 1'b1;
      if (s.phase != PH_IDLE && s.rem == '0 &&
          (s.verdict == V_PNG || s.verdict == V_JPEG)) begin
        res_o.image_kind   = s.verdict;
        res_o.image_width  = s.width;
        res_o.image_height = s.height;
      end else begin
        res_o.image_kind = KIND_REJECT;
      end
      s = '0;
      s.phase   = PH_IDLE;
      s.verdict = V_UNDECIDED;
    end
  end

  assign st_o = s;

endmodule

### design/idhp_obuf.sv
// ----------------------------------------------------------------------------
// Image header dimension parser: result buffer
// Output register with one skid entry, so a new result can land while the
// previous one is still held by the receiver.
// ----------------------------------------------------------------------------
`include "image_header_dimension_parser_defines.svh"

module idhp_obuf (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push_i,
  input  idhp_pkg::idhp_out_t push_data_i,
  output logic                full_o,
  output logic                out_valid,
  input  logic                out_stall,
  output idhp_pkg::idhp_out_t out_data
);
  import idhp_pkg::*;

  logic      out_valid_r, out_valid_nxt;
  idhp_out_t out_data_r, out_data_nxt;
  logic      skid_valid_r, skid_valid_nxt;
  idhp_out_t skid_data_r, skid_data_nxt;
  logic      take;

  assign take = out_valid_r && !out_stall;

  // Refill the output slot from the skid entry first, park new results
  // in the skid entry while the output is held
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (!out_valid_r || take) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = push_i;
        out_data_nxt  = push_data_i;
      end
    end else if (push_i) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = push_data_i;
    end
  end

  // Hold control under reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign full_o    = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `IDHP_ASSERT(a_skid_behind_out, skid_valid_r |-> out_valid_r, "skid holds a result ahead of the output")
  `IDHP_ASSERT(a_no_push_full, push_i |-> !skid_valid_r, "result pushed into a full buffer")
  `IDHP_ASSERT(a_skid_fill_held, $rose(skid_valid_r) |-> $past(out_valid_r && out_stall), "skid filled while the output was free")
  `IDHP_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> (!out_valid_r && !skid_valid_r), "buffer not empty after reset")

endmodule

### design/image_header_dimension_parser.sv
// ----------------------------------------------------------------------------
// Image header dimension parser
// Reads a PNG or JPEG file one byte per request and reports the image kind
// and pixel dimensions on the final byte.
// ----------------------------------------------------------------------------
// The block takes one byte per cycle while in_stall is low: each accepted byte
// updates the parser state in a single pass of logic, so bytes may arrive back
// to back with no gaps. The verdict for a file is registered once its
// end_of_file byte is accepted. Results sit in a two-entry buffer (output
// register plus one skid entry); in_stall rises only while both entries hold
// results the receiver has not taken. start_of_file restarts parsing at any
// time; bytes with no open file are dropped, but end_of_file gives a reject.
module image_header_dimension_parser #(
  parameter logic [31:0] MAX_FILE_BYTES = 32'd16777216
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  idhp_pkg::idhp_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output idhp_pkg::idhp_out_t out_data
);
  import idhp_pkg::*;

  idhp_state_t st_r, st_nxt;
  idhp_state_t step_st;
  idhp_out_t   res;
  logic        res_valid;
  logic        in_take;
  logic        buf_full;

  assign in_stall = buf_full;
  assign in_take  = in_valid && !buf_full;

  // Per-byte parser update
  idhp_step #(
    .MAX_FILE_BYTES(MAX_FILE_BYTES)
  ) u_step (
    .st_i        (st_r),
    .req_i       (in_data),
    .st_o        (step_st),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  assign st_nxt = in_take ? step_st : st_r;

  // Hold parser state, clear under reset (idle phase, undecided verdict)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else begin
      st_r <= st_nxt;
    end
  end

  // Result buffer
  idhp_obuf u_obuf (
    .clk         (clk),
    .rst_n       (rst_n),
    .push_i      (in_take && res_valid),
    .push_data_i (res),
    .full_o      (buf_full),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

endmodule
